// ===== rtl/ufd_pkg.sv =====
// ufd_pkg: shared types and constants for the UDP frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ufd_pkg;

   localparam int unsigned CSR_DATA_W = 15;

   // configuration register indexes
   localparam logic CSR_BUFFER_LIMIT   = 1'b0;
   localparam logic CSR_CONNECTED_MODE = 1'b1;

   localparam logic [CSR_DATA_W-1:0] BUFFER_LIMIT_RESET = 15'd16384;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_HEADER  = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // error codes
   localparam logic [1:0] ERR_TOO_LARGE   = 2'd0;
   localparam logic [1:0] ERR_NO_BUFFER   = 2'd1;
   localparam logic [1:0] ERR_BAD_DGRAM   = 2'd2;

   // framing constants
   localparam logic [4:0] LEN_BYTES  = 5'd4;
   localparam logic [4:0] HDR_V4_LEN = 5'd8;
   localparam logic [4:0] HDR_V6_LEN = 5'd20;
   localparam logic [4:0] HDR_FAMILY = 5'd0;
   localparam logic [4:0] HDR_PORT_H = 5'd2;
   localparam logic [4:0] HDR_PORT_L = 5'd3;
   localparam logic [4:0] HDR_ADDR   = 5'd4;
   localparam logic [7:0] FAMILY_V4  = 8'd4;
   localparam logic [7:0] FAMILY_V6  = 8'd6;

   typedef enum logic [5:0] {
      PH_LEN   = 6'b000001,
      PH_DRAIN = 6'b000010,
      PH_RAW   = 6'b000100,
      PH_HDR   = 6'b001000,
      PH_PAY   = 6'b010000,
      PH_BAD   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] buffer_limit;
      logic                  connected_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic        last;
      logic        family_v6;
      logic [15:0] port;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [14:0] payload_length;
      logic [1:0]  error_code;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } step_type;

endpackage

// ===== rtl/ufd_if.sv =====
// ufd_if: valid/ready channel interfaces for the deframer's byte input
// and result output. Standalone; no package dependency.
`timescale 1ns / 1ps

interface ufd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface ufd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic        last;
   logic        family_v6;
   logic [15:0] port;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic [14:0] payload_length;
   logic [1:0]  error_code;

   modport source (output valid, output kind, output out_byte, output last,
                   output family_v6, output port, output addr_high,
                   output addr_low, output payload_length, output error_code,
                   input ready);
   modport sink   (input valid, input kind, input out_byte, input last,
                   input family_v6, input port, input addr_high,
                   input addr_low, input payload_length, input error_code,
                   output ready);
endinterface

// ===== rtl/ufd_csr.sv =====
// ufd_csr: configuration registers (buffer limit, connected mode).
// Depends on ufd_pkg.
`timescale 1ns / 1ps

module ufd_csr
   import ufd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [CSR_DATA_W-1:0] limit_ff, limit_in;
   logic                  conn_ff, conn_in;

   always_comb begin
      limit_in = limit_ff;
      conn_in  = conn_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BUFFER_LIMIT:   limit_in = csr_wdata;
            CSR_CONNECTED_MODE: conn_in  = csr_wdata[0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= BUFFER_LIMIT_RESET;
         conn_ff  <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         conn_ff  <= conn_in;
      end
   end

   assign cfg.buffer_limit   = limit_ff;
   assign cfg.connected_mode = conn_ff;

endmodule

// ===== rtl/ufd_parser.sv =====
// ufd_parser: input register plus the per-byte frame parser state machine.
// Depends on ufd_pkg; produces at most one result per accepted byte.
`timescale 1ns / 1ps

module ufd_parser
   import ufd_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 16384
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   output logic       in_ready,
   input  cfg_type    cfg,
   input  logic       out_free,
   output step_type   step,
   output logic       step_take
);

   localparam int unsigned REM_W   = $clog2(MAX_FRAME + 1);
   localparam logic [31:0] MAX_LEN = 32'(MAX_FRAME);

   logic             hold_valid_ff, hold_valid_in;
   logic [7:0]       hold_byte_ff;
   logic             advance;

   phase_type        phase_ff, phase_in;
   logic [23:0]      len_ff, len_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             fam_ff, fam_in;
   logic [15:0]      port_ff, port_in;
   logic [127:0]     addr_ff, addr_in;

   logic [REM_W-1:0] rem_dec;
   logic             rem_zero;
   logic [31:0]      n;
   logic [4:0]       cnt_inc;
   logic             fam_v;
   logic             err_fire;
   logic [1:0]       err_code;
   logic [7:0]       b;

   assign b        = hold_byte_ff;
   assign rem_dec  = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
   assign rem_zero = (rem_dec == '0);
   assign n        = {len_ff, b};
   assign cnt_inc  = cnt_ff + 5'd1;

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      fam_in     = fam_ff;
      port_in    = port_ff;
      addr_in    = addr_ff;
      step       = '0;
      err_fire   = 1'b0;
      err_code   = ERR_TOO_LARGE;
      fam_v      = fam_ff;

      unique case (phase_ff)
         PH_DRAIN: begin
            rem_in = rem_dec;
            if (rem_zero) begin
               err_fire = 1'b1;
               err_code = ERR_NO_BUFFER;
            end
         end
         PH_RAW, PH_PAY: begin
            rem_in             = rem_dec;
            step.valid         = 1'b1;
            step.data.kind     = KIND_PAYLOAD;
            step.data.out_byte = b;
            if (rem_zero) begin
               step.data.last = 1'b1;
               phase_in       = PH_LEN;
               cnt_in         = '0;
               len_in         = '0;
            end
         end
         PH_BAD: begin
            rem_in = rem_dec;
            if (rem_zero) begin
               err_fire = 1'b1;
               err_code = ERR_BAD_DGRAM;
            end
         end
         PH_HDR: begin
            rem_in = rem_dec;
            if (cnt_ff == HDR_FAMILY && b != FAMILY_V4 && b != FAMILY_V6) begin
               if (rem_zero) begin
                  err_fire = 1'b1;
                  err_code = ERR_BAD_DGRAM;
               end else begin
                  phase_in = PH_BAD;
               end
            end else begin
               if (cnt_ff == HDR_FAMILY) begin
                  fam_v = (b == FAMILY_V6);
               end else if (cnt_ff == HDR_PORT_H) begin
                  port_in = {b, 8'h00};
               end else if (cnt_ff == HDR_PORT_L) begin
                  port_in = {port_ff[15:8], b};
               end else if (cnt_ff >= HDR_ADDR) begin
                  addr_in = {addr_ff[119:0], b};
               end
               fam_in = fam_v;
               cnt_in = cnt_inc;
               if (cnt_inc == (fam_v ? HDR_V6_LEN : HDR_V4_LEN)) begin
                  step.valid               = 1'b1;
                  step.data.kind           = KIND_HEADER;
                  step.data.family_v6      = fam_v;
                  step.data.port           = port_in;
                  step.data.addr_high      = addr_in[127:64];
                  step.data.addr_low       = addr_in[63:0];
                  step.data.payload_length = 15'(rem_dec);
                  if (rem_zero) begin
                     step.data.last = 1'b1;
                     phase_in       = PH_LEN;
                     cnt_in         = '0;
                     len_in         = '0;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end else if (rem_zero) begin
                  err_fire = 1'b1;
                  err_code = ERR_BAD_DGRAM;
               end
            end
         end
         PH_LEN: begin
            if (cnt_inc < LEN_BYTES) begin
               len_in = n[23:0];
               cnt_in = cnt_inc;
            end else begin
               len_in = '0;
               cnt_in = '0;
               if (n > MAX_LEN) begin
                  err_fire = 1'b1;
                  err_code = ERR_TOO_LARGE;
               end else if (n > 32'(cfg.buffer_limit)) begin
                  rem_in   = REM_W'(n);
                  phase_in = PH_DRAIN;
               end else begin
                  rem_in = REM_W'(n);
                  if (cfg.connected_mode) begin
                     if (n == '0) begin
                        step.valid     = 1'b1;
                        step.data.kind = KIND_EMPTY;
                        step.data.last = 1'b1;
                     end else begin
                        phase_in = PH_RAW;
                     end
                  end else if (n == '0) begin
                     err_fire = 1'b1;
                     err_code = ERR_BAD_DGRAM;
                  end else begin
                     fam_in   = 1'b0;
                     port_in  = '0;
                     addr_in  = '0;
                     phase_in = PH_HDR;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_LEN;
            cnt_in   = '0;
            len_in   = '0;
         end
      endcase

      if (err_fire) begin
         step                 = '0;
         step.valid           = 1'b1;
         step.data.kind       = KIND_ERROR;
         step.data.last       = 1'b1;
         step.data.error_code = err_code;
         phase_in             = PH_LEN;
         cnt_in               = '0;
         len_in               = '0;
      end
   end

   // a byte that yields no result never waits on the output register
   assign advance       = hold_valid_ff && (!step.valid || out_free);
   assign step_take     = advance && step.valid;
   assign in_ready      = !hold_valid_ff || advance;
   assign hold_valid_in = in_valid ? 1'b1 : (hold_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= PH_LEN;
         len_ff        <= '0;
         cnt_ff        <= '0;
         rem_ff        <= '0;
         fam_ff        <= 1'b0;
         port_ff       <= '0;
         addr_ff       <= '0;
      end else begin
         if (in_ready) begin
            hold_valid_ff <= hold_valid_in;
         end
         if (advance) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            cnt_ff   <= cnt_in;
            rem_ff   <= rem_in;
            fam_ff   <= fam_in;
            port_ff  <= port_in;
            addr_ff  <= addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hold_byte_ff <= in_byte;
      end
   end

endmodule

// ===== rtl/udp_frame_deframer_unit.sv =====
// udp_frame_deframer_unit: top level of the length-prefixed frame deframer.
// Depends on ufd_pkg, ufd_if, ufd_csr and ufd_parser.
//
// Usage:
//   req carries one byte of the framed stream per transfer. Each frame is a
//   4-byte big-endian length then that many bytes. rsp carries results:
//   payload bytes, at most one address header per unconnected frame, an empty-frame
//   marker or an error; the final result of a frame has last set.
//   csr_write_en/csr_index/csr_wdata write buffer_limit (index 0) and
//   connected_mode (index 1); write only while the block is idle.
// Timing:
//   One byte per cycle sustained while rsp is not stalled. A byte is held in
//   the input register, the parser state machine updates and its result
//   lands in the output register, which drives rsp. The single parser stage
//   sets the rate.
// Reset:
//   Synchronous, active high. Parsing restarts at a length field,
//   buffer_limit returns to 16384, connected_mode to 0, both registers empty.
// Stalls:
//   While rsp is stalled, a held result stays; bytes that give no result still
//   pass, and req.ready drops only when a new result would have nowhere to go.
`timescale 1ns / 1ps

module udp_frame_deframer_unit
   import ufd_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   ufd_req_if.sink               req,
   ufd_rsp_if.source             rsp,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg;
   step_type        step;
   logic            step_take;
   logic            out_free;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   ufd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ufd_parser #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_byte   (req.in_byte),
      .in_ready  (req.ready),
      .cfg       (cfg),
      .out_free  (out_free),
      .step      (step),
      .step_take (step_take)
   );

   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = step_take ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_take) begin
         rsp_data_ff <= step.data;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_data_ff.kind;
   assign rsp.out_byte       = rsp_data_ff.out_byte;
   assign rsp.last           = rsp_data_ff.last;
   assign rsp.family_v6      = rsp_data_ff.family_v6;
   assign rsp.port           = rsp_data_ff.port;
   assign rsp.addr_high      = rsp_data_ff.addr_high;
   assign rsp.addr_low       = rsp_data_ff.addr_low;
   assign rsp.payload_length = rsp_data_ff.payload_length;
   assign rsp.error_code     = rsp_data_ff.error_code;

endmodule

// ===== rtl/ufd_checker.sv =====
// ufd_checker: port-level assertions for udp_frame_deframer_unit.
// Depends on ufd_pkg; attached to the top level by the bind below.
`timescale 1ns / 1ps

module ufd_checker
   import ufd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last,
   input logic [15:0] rsp_port,
   input logic [63:0] rsp_addr_high,
   input logic [63:0] rsp_addr_low
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ERROR || rsp_kind == KIND_EMPTY) |-> rsp_last)
      else $error("error or empty result without last");

   a_non_header_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_HEADER
         |-> rsp_port == '0 && rsp_addr_high == '0 && rsp_addr_low == '0)
      else $error("address fields set on a non-header result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

endmodule

bind udp_frame_deframer_unit ufd_checker u_ufd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_kind      (rsp.kind),
   .rsp_out_byte  (rsp.out_byte),
   .rsp_last      (rsp.last),
   .rsp_port      (rsp.port),
   .rsp_addr_high (rsp.addr_high),
   .rsp_addr_low  (rsp.addr_low)
);
